>>> sv/mrtq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the multi-reader topic queue.
// No dependencies; compile first.
package mrtq_pkg;

    localparam int NUM_SUBS        = 3;
    localparam int NUM_TOPICS      = 2;
    localparam int NUM_PAIRS       = NUM_SUBS * NUM_TOPICS;
    localparam int SUB_W           = 2;
    localparam int MASK_W          = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int PAIR_W          = 3;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_TOKEN_WIDTH = 64;

    typedef logic [MASK_W-1:0] sub_mask_t;

    localparam sub_mask_t ALL_READ        = 3'b111;
    localparam sub_mask_t TOPIC0_SUBS_RST = 3'd3;
    localparam sub_mask_t TOPIC1_SUBS_RST = 3'd6;

    typedef enum logic [0:0] {
        KIND_PUBLISH = 1'b0,
        KIND_REQUEST = 1'b1
    } item_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOPIC0_SUBS = 1'b0,
        REG_TOPIC1_SUBS = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUB,
        ST_REL_RD,
        ST_REL_CHK,
        ST_DINIT,
        ST_DSCAN,
        ST_DRD,
        ST_DWR
    } seq_state_t;

endpackage

>>> sv/mrtq_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the multi-reader topic queue: items in, deliveries out,
// configuration writes. Depends on mrtq_pkg.
interface mrtq_in_if #(parameter int TOKEN_WIDTH = mrtq_pkg::DEF_TOKEN_WIDTH);
    import mrtq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic                   topic;
    logic [SUB_W-1:0]       subscriber;
    logic [TOKEN_WIDTH-1:0] token;

    modport source (output valid, output kind, output topic, output subscriber,
                    output token, input ready);
    modport sink   (input valid, input kind, input topic, input subscriber,
                    input token, output ready);
endinterface

interface mrtq_out_if #(parameter int TOKEN_WIDTH = mrtq_pkg::DEF_TOKEN_WIDTH);
    import mrtq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SUB_W-1:0]       dest;
    logic                   from_topic;
    logic [TOKEN_WIDTH-1:0] data_word;
    logic                   last;

    modport source (output valid, output dest, output from_topic, output data_word,
                    output last, input ready);
    modport sink   (input valid, input dest, input from_topic, input data_word,
                    input last, output ready);
endinterface

interface mrtq_cfg_if;
    import mrtq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MASK_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mrtq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrtq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/multi_reader_topic_queue.sv
`timescale 1ns / 1ps
// Top level of the multi-reader topic queue: sequencer, queue pointers, reader state.
// Depends on mrtq_pkg, mrtq_ifs (channel interfaces) and mrtq_ram.
//
//  channel   dir  handshake      payload
//  inbound   in   valid/ready    kind, topic, subscriber, token
//  outbound  out  valid/ready    dest, from_topic, data_word, last
//  cfg       in   valid/ready    index, data (subscriber masks, always ready)
//
// One item at a time. A publish writes the token and its read marks, then frees fully
// read slots at the head. Then eligibility is set up and the subscriber/topic pairs are
// scanned, ending with a closing scan; each delivery reads the slot, writes the outbound
// register and the read mark, then frees fully read slots. The token and read-mark RAMs
// each have a single read port. Deliveries wait while outbound stalls. After reset a
// clearing pass writes every read mark of both topics to zero before inbound goes ready.
module multi_reader_topic_queue #(
    parameter int QUEUE_DEPTH = mrtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TOKEN_WIDTH = mrtq_pkg::DEF_TOKEN_WIDTH
) (
    input logic        clk,
    input logic        rst_n,
    mrtq_in_if.sink    inbound,
    mrtq_out_if.source outbound,
    mrtq_cfg_if.sink   cfg
);
    import mrtq_pkg::*;

    localparam int AW        = $clog2(QUEUE_DEPTH);
    localparam int FW        = $clog2(QUEUE_DEPTH + 1);
    localparam int RAW       = AW + 1;
    localparam int RAM_DEPTH = NUM_TOPICS << AW;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    seq_state_t             state_reg, state_next;
    logic [PAIR_W-1:0]      idx_reg, idx_next;
    logic [NUM_PAIRS-1:0]   elig_reg, elig_next;
    logic                   deliv_reg, deliv_next;
    logic                   top_reg, top_next;
    logic [TOKEN_WIDTH-1:0] tok_reg, tok_next;
    logic [RAW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]          head_reg [NUM_TOPICS];
    logic [AW-1:0]          head_next [NUM_TOPICS];
    logic [AW-1:0]          tail_reg [NUM_TOPICS];
    logic [AW-1:0]          tail_next [NUM_TOPICS];
    logic [FW-1:0]          fill_reg [NUM_TOPICS];
    logic [FW-1:0]          fill_next [NUM_TOPICS];
    logic [AW-1:0]          rpos_reg [NUM_TOPICS][NUM_SUBS];
    logic [AW-1:0]          rpos_next [NUM_TOPICS][NUM_SUBS];
    logic [NUM_SUBS-1:0]    has_reg [NUM_TOPICS];
    logic [NUM_SUBS-1:0]    has_next [NUM_TOPICS];
    logic [NUM_SUBS-1:0]    pend_reg, pend_next;
    sub_mask_t              mask_reg [NUM_TOPICS];

    logic                   out_valid_reg, out_valid_next;
    logic [SUB_W-1:0]       out_dest_reg, out_dest_next;
    logic                   out_topic_reg, out_topic_next;
    logic [TOKEN_WIDTH-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic                   tok_we;
    logic [RAW-1:0]         tok_waddr, tok_raddr;
    logic [TOKEN_WIDTH-1:0] tok_rdata;
    logic                   mark_we;
    logic [RAW-1:0]         mark_waddr, mark_raddr;
    sub_mask_t              mark_wdata, mark_rdata;

    logic                   sel_t;
    logic [SUB_W-1:0]       cur_sub;
    sub_mask_t              sel_mask;
    logic [AW-1:0]          cur_pos;
    logic [AW-1:0]          cur_pos_nx;
    logic                   full;
    logic                   out_free;

    mrtq_ram #(.WIDTH(TOKEN_WIDTH), .DEPTH(RAM_DEPTH)) u_tok_ram (
        .clk   (clk),
        .we    (tok_we),
        .waddr (tok_waddr),
        .wdata (tok_reg),
        .raddr (tok_raddr),
        .rdata (tok_rdata)
    );

    mrtq_ram #(.WIDTH(MASK_W), .DEPTH(RAM_DEPTH)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign inbound.ready       = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign outbound.valid      = out_valid_reg;
    assign outbound.dest       = out_dest_reg;
    assign outbound.from_topic = out_topic_reg;
    assign outbound.data_word  = out_data_reg;
    assign outbound.last       = out_last_reg;

    // topic in work: the pair's topic while delivering, the published one otherwise
    assign sel_t      = deliv_reg ? idx_reg[0] : top_reg;
    assign cur_sub    = idx_reg[PAIR_W-1:1];
    assign sel_mask   = mask_reg[sel_t];
    assign cur_pos    = rpos_reg[sel_t][cur_sub];
    assign cur_pos_nx = next_slot(cur_pos);
    assign full       = (fill_reg[sel_t] == FW'(QUEUE_DEPTH));
    assign out_free   = !out_valid_reg || outbound.ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        elig_next      = elig_reg;
        deliv_next     = deliv_reg;
        top_next       = top_reg;
        tok_next       = tok_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        rpos_next      = rpos_reg;
        has_next       = has_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !outbound.ready;
        out_dest_next  = out_dest_reg;
        out_topic_next = out_topic_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        tok_we         = 1'b0;
        tok_waddr      = {sel_t, tail_reg[sel_t]};
        tok_raddr      = {sel_t, cur_pos};
        mark_we        = 1'b0;
        mark_waddr     = {sel_t, tail_reg[sel_t]};
        mark_wdata     = ~sel_mask;
        mark_raddr     = {sel_t, cur_pos};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                deliv_next = 1'b0;
                if (inbound.valid)
                begin
                    if (inbound.kind == KIND_PUBLISH)
                    begin
                        top_next   = inbound.topic;
                        tok_next   = inbound.token;
                        state_next = ST_PUB;
                    end
                    else
                    begin
                        if (inbound.subscriber < SUB_W'(NUM_SUBS))
                        begin
                            pend_next[inbound.subscriber] = 1'b1;
                        end
                        state_next = ST_DINIT;
                    end
                end
            end

            ST_PUB:
            begin
                tok_we  = 1'b1;
                mark_we = 1'b1;
                if (full)
                begin
                    head_next[sel_t] = next_slot(head_reg[sel_t]);
                end
                else
                begin
                    fill_next[sel_t] = fill_reg[sel_t] + 1'b1;
                end
                for (int s = 0; s < NUM_SUBS; s++)
                begin
                    // readers parked on the overwritten head skip to the new head
                    if (full && has_reg[sel_t][s] && rpos_reg[sel_t][s] == head_reg[sel_t])
                    begin
                        rpos_next[sel_t][s] = next_slot(head_reg[sel_t]);
                    end
                    if (sel_mask[s] && !has_reg[sel_t][s])
                    begin
                        rpos_next[sel_t][s] = tail_reg[sel_t];
                        has_next[sel_t][s]  = 1'b1;
                    end
                end
                tail_next[sel_t] = next_slot(tail_reg[sel_t]);
                state_next       = ST_REL_RD;
            end

            ST_REL_RD:
            begin
                mark_raddr = {sel_t, head_reg[sel_t]};
                if (fill_reg[sel_t] != '0)
                begin
                    state_next = ST_REL_CHK;
                end
                else if (deliv_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DSCAN;
                end
                else
                begin
                    state_next = ST_DINIT;
                end
            end

            ST_REL_CHK:
            begin
                if (mark_rdata == ALL_READ)
                begin
                    head_next[sel_t] = next_slot(head_reg[sel_t]);
                    fill_next[sel_t] = fill_reg[sel_t] - 1'b1;
                    state_next       = ST_REL_RD;
                end
                else if (deliv_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DSCAN;
                end
                else
                begin
                    state_next = ST_DINIT;
                end
            end

            ST_DINIT:
            begin
                // a pair's eligibility is not touched by other pairs' deliveries
                for (int s = 0; s < NUM_SUBS; s++)
                begin
                    for (int t = 0; t < NUM_TOPICS; t++)
                    begin
                        elig_next[s * NUM_TOPICS + t] =
                            pend_reg[s] && mask_reg[t][s] && has_reg[t][s];
                    end
                end
                idx_next   = '0;
                deliv_next = 1'b1;
                state_next = ST_DSCAN;
            end

            ST_DSCAN:
            begin
                if (elig_reg == '0)
                begin
                    deliv_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (elig_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        state_next = ST_DRD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_DRD:
            begin
                state_next = ST_DWR;
            end

            ST_DWR:
            begin
                elig_next[idx_reg] = 1'b0;
                out_valid_next     = 1'b1;
                out_dest_next      = cur_sub;
                out_topic_next     = sel_t;
                out_data_next      = tok_rdata;
                out_last_next      = ((elig_reg & ~(NUM_PAIRS'(1) << idx_reg)) == '0);
                mark_we            = 1'b1;
                mark_waddr         = {sel_t, cur_pos};
                mark_wdata         = mark_rdata | (MASK_W'(1) << cur_sub);
                rpos_next[sel_t][cur_sub] = cur_pos_nx;
                if (cur_pos_nx == tail_reg[sel_t])
                begin
                    has_next[sel_t][cur_sub] = 1'b0;
                end
                pend_next[cur_sub] = 1'b0;
                state_next         = ST_REL_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            elig_reg      <= '0;
            deliv_reg     <= 1'b0;
            top_reg       <= 1'b0;
            clr_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TOPICS; t++)
            begin
                head_reg[t] <= '0;
                tail_reg[t] <= '0;
                fill_reg[t] <= '0;
                has_reg[t]  <= '0;
                for (int s = 0; s < NUM_SUBS; s++)
                begin
                    rpos_reg[t][s] <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            elig_reg      <= elig_next;
            deliv_reg     <= deliv_next;
            top_reg       <= top_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            has_reg       <= has_next;
            rpos_reg      <= rpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg       <= tok_next;
        out_dest_reg  <= out_dest_next;
        out_topic_reg <= out_topic_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= TOPIC0_SUBS_RST;
            mask_reg[1] <= TOPIC1_SUBS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TOPIC0_SUBS: mask_reg[0] <= cfg.data;
                REG_TOPIC1_SUBS: mask_reg[1] <= cfg.data;
                default:         mask_reg[0] <= mask_reg[0];
            endcase
        end
    end

endmodule

>>> sv/mrtq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for multi_reader_topic_queue, attached by bind.
// Depends on mrtq_pkg and the top level.
module mrtq_checker #(
    parameter int TOKEN_WIDTH = mrtq_pkg::DEF_TOKEN_WIDTH
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mrtq_pkg::SUB_W-1:0]     out_dest,
    input logic                           out_from_topic,
    input logic [TOKEN_WIDTH-1:0]         out_data_word,
    input logic                           out_last
);
    import mrtq_pkg::*;

    // a stalled delivery keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_dest)
            && $stable(out_from_topic) && $stable(out_data_word) && $stable(out_last))
        else $error("delivery changed while stalled");

    // one item at a time: the block is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");

    a_dest_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_dest < SUB_W'(NUM_SUBS))
        else $error("delivery to a nonexistent subscriber");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_ready)
        else $error("channel active during reset");

endmodule

bind multi_reader_topic_queue mrtq_checker #(.TOKEN_WIDTH(TOKEN_WIDTH)) u_mrtq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (inbound.valid),
    .in_ready       (inbound.ready),
    .out_valid      (outbound.valid),
    .out_ready      (outbound.ready),
    .out_dest       (outbound.dest),
    .out_from_topic (outbound.from_topic),
    .out_data_word  (outbound.data_word),
    .out_last       (outbound.last)
);

>>> tb/multi_reader_topic_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_reader_topic_queue: directed fan-out cases, then random
// publish/request traffic under several subscriber masks. Depends on mrtq_pkg and mrtq_ifs.
module multi_reader_topic_queue_tb;
    import mrtq_pkg::*;

    localparam int DEPTH         = DEF_QUEUE_DEPTH;
    localparam int TOKEN_W       = DEF_TOKEN_WIDTH;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [SUB_W-1:0]   dest;
        logic               from_topic;
        logic [TOKEN_W-1:0] data_word;
        logic               last;
    } delivery_t;

    logic clk;
    logic rst_n;

    mrtq_in_if  inbound ();
    mrtq_out_if outbound ();
    mrtq_cfg_if cfg ();

    multi_reader_topic_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .inbound  (inbound),
        .outbound (outbound),
        .cfg      (cfg)
    );

    // shadow copy of the queues, reader cursors and masks
    bit [TOKEN_W-1:0] ring_word [NUM_TOPICS][DEPTH];
    bit [MASK_W-1:0]  ring_marks[NUM_TOPICS][DEPTH];
    int               ring_head [NUM_TOPICS];
    int               ring_tail [NUM_TOPICS];
    int               ring_fill [NUM_TOPICS];
    int               cursor     [NUM_TOPICS][NUM_SUBS];
    bit               cursor_live[NUM_TOPICS][NUM_SUBS];
    bit               waiting    [NUM_SUBS];
    sub_mask_t        topic_mask [NUM_TOPICS] = '{TOPIC0_SUBS_RST, TOPIC1_SUBS_RST};

    delivery_t deliveries_due[$];

    int errors     = 0;
    int items_sent = 0;
    int publishes  = 0;
    int overwrites = 0;
    int delivered  = 0;
    int max_batch  = 0;
    int mask_loads = 0;
    int cycles     = 0;
    bit quiet      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d deliveries still due", $time, deliveries_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int wrap_inc(int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void free_read_slots(int t);
        while (ring_fill[t] > 0 && ring_marks[t][ring_head[t]] == ALL_READ)
        begin
            ring_head[t] = wrap_inc(ring_head[t]);
            ring_fill[t]--;
        end
    endfunction

    function automatic void model_publish(int t, logic [TOKEN_W-1:0] w);
        int slot;
        slot = ring_tail[t];
        if (ring_fill[t] >= DEPTH)
        begin
            // full: oldest slot is lost, readers parked on it move to the new head
            overwrites++;
            for (int s = 0; s < NUM_SUBS; s++)
                if (cursor_live[t][s] && cursor[t][s] == ring_head[t])
                    cursor[t][s] = wrap_inc(ring_head[t]);
            ring_head[t] = wrap_inc(ring_head[t]);
        end
        else
        begin
            ring_fill[t]++;
        end
        ring_word[t][slot]  = w;
        ring_marks[t][slot] = ~topic_mask[t];
        for (int s = 0; s < NUM_SUBS; s++)
        begin
            if (topic_mask[t][s] && !cursor_live[t][s])
            begin
                cursor[t][s]      = slot;
                cursor_live[t][s] = 1'b1;
            end
        end
        ring_tail[t] = wrap_inc(slot);
        free_read_slots(t);
    endfunction

    function automatic logic [TOKEN_W-1:0] model_take(int s, int t);
        int p;
        logic [TOKEN_W-1:0] w;
        p = cursor[t][s];
        w = ring_word[t][p];
        ring_marks[t][p][s] = 1'b1;
        p = wrap_inc(p);
        cursor[t][s] = p;
        if (p == ring_tail[t])
            cursor_live[t][s] = 1'b0;
        free_read_slots(t);
        return w;
    endfunction

    function automatic void predict_deliveries(item_kind_t k, logic tp, logic [SUB_W-1:0] sb,
                                               logic [TOKEN_W-1:0] w);
        delivery_t batch[6];
        int n;
        n = 0;
        if (k == KIND_PUBLISH)
            model_publish(tp, w);
        else if (sb < NUM_SUBS)
            waiting[sb] = 1'b1;
        // pending readers in order, topic 0 before topic 1
        for (int s = 0; s < NUM_SUBS; s++)
        begin
            if (waiting[s])
            begin
                for (int t = 0; t < NUM_TOPICS; t++)
                begin
                    if (topic_mask[t][s] && cursor_live[t][s])
                    begin
                        batch[n].dest       = s[SUB_W-1:0];
                        batch[n].from_topic = t[0];
                        batch[n].data_word  = model_take(s, t);
                        batch[n].last       = 1'b0;
                        n++;
                        waiting[s] = 1'b0;
                    end
                end
            end
        end
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            deliveries_due.push_back(batch[i]);
        if (n > max_batch)
            max_batch = n;
    endfunction

    function automatic void check_field(string name, logic [TOKEN_W-1:0] want,
                                        logic [TOKEN_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // result side: random stall bursts unless in the quiet tail
    initial
    begin
        int hold;
        hold = 0;
        outbound.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                outbound.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 4) - 1;
                outbound.ready <= 1'b0;
            end
            else
            begin
                outbound.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        delivery_t want;
        if (outbound.valid && outbound.ready)
        begin
            if (deliveries_due.size() == 0)
            begin
                errors++;
                $display("%0t: extra delivery, expected none actual %0d/%0d/%h/%0b",
                         $time, outbound.dest, outbound.from_topic, outbound.data_word,
                         outbound.last);
            end
            else
            begin
                want = deliveries_due.pop_front();
                check_field("dest", want.dest, outbound.dest);
                check_field("from_topic", want.from_topic, outbound.from_topic);
                check_field("data_word", want.data_word, outbound.data_word);
                check_field("last", want.last, outbound.last);
                delivered++;
            end
        end
    end

    function automatic logic [TOKEN_W-1:0] random_token();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(item_kind_t k, logic tp, logic [SUB_W-1:0] sb,
                             logic [TOKEN_W-1:0] w);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            inbound.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        inbound.valid      <= 1'b1;
        inbound.kind       <= k;
        inbound.topic      <= tp;
        inbound.subscriber <= sb;
        inbound.token      <= w;
        @(posedge clk);
        while (!inbound.ready) @(posedge clk);
        items_sent++;
        if (k == KIND_PUBLISH)
            publishes++;
        predict_deliveries(k, tp, sb, w);
    endtask

    // wait for all deliveries, then let a publish with a long free chain finish
    task automatic settle();
        inbound.valid <= 1'b0;
        while (deliveries_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_masks(sub_mask_t m0, sub_mask_t m1);
        cfg.valid <= 1'b1;
        cfg.index <= REG_TOPIC0_SUBS;
        cfg.data  <= m0;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        topic_mask[REG_TOPIC0_SUBS] = m0;
        cfg.index <= REG_TOPIC1_SUBS;
        cfg.data  <= m1;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        topic_mask[REG_TOPIC1_SUBS] = m1;
        cfg.valid <= 1'b0;
        mask_loads++;
    endtask

    // reset masks: pending reader served on publish, two-topic reader, ignored fields
    task automatic test_default_masks();
        send_item(KIND_REQUEST, 1'b1, 2'd0, '1);
        send_item(KIND_PUBLISH, 1'b0, 2'd3, '1);
        send_item(KIND_PUBLISH, 1'b1, 2'd0, '0);
        send_item(KIND_REQUEST, 1'b0, 2'd1, '0);
        send_item(KIND_REQUEST, 1'b1, 2'd3, '1);
        send_item(KIND_PUBLISH, 1'b0, 2'd2, {32{2'b10}});
        send_item(KIND_REQUEST, 1'b1, 2'd2, {32{2'b01}});
        send_item(KIND_REQUEST, 1'b0, 2'd2, '1);
        settle();
    endtask

    // readers left pending after unsubscribing, then all six pairs released by one item
    task automatic test_full_fanout();
        load_masks(3'd7, 3'd7);
        send_item(KIND_PUBLISH, 1'b0, 2'd1, 64'h0123_4567_89ab_cdef);
        send_item(KIND_PUBLISH, 1'b1, 2'd2, 64'hfedc_ba98_7654_3210);
        settle();
        load_masks(3'd0, 3'd0);
        send_item(KIND_PUBLISH, 1'b1, 2'd0, 64'h8000_0000_0000_0001);
        send_item(KIND_REQUEST, 1'b0, 2'd0, '0);
        send_item(KIND_REQUEST, 1'b1, 2'd1, '0);
        send_item(KIND_REQUEST, 1'b0, 2'd2, '0);
        settle();
        load_masks(3'd7, 3'd7);
        send_item(KIND_REQUEST, 1'b0, 2'd3, '0);
        send_item(KIND_PUBLISH, 1'b0, 2'd0, 64'h0000_0000_ffff_ffff);
        send_item(KIND_REQUEST, 1'b1, 2'd1, '1);
        settle();
    endtask

    task automatic run_phase(sub_mask_t m0, sub_mask_t m1, int pub_pct, int t0_pct,
                             int count);
        logic tp;
        load_masks(m0, m1);
        for (int i = 0; i < count; i++)
        begin
            tp = ($urandom_range(0, 99) < t0_pct) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 99) < pub_pct)
                send_item(KIND_PUBLISH, tp, SUB_W'($urandom_range(0, 3)), random_token());
            else
                send_item(KIND_REQUEST, tp, SUB_W'($urandom_range(0, 3)), random_token());
        end
        settle();
    endtask

    // floods overrun the 32-deep rings; mask changes leave stale readers behind
    task automatic test_random_traffic();
        run_phase(3'd3, 3'd6, 50, 50, 40);
        run_phase(3'd7, 3'd7, 92, 90, 50);
        run_phase(3'd1, 3'd2, 40, 50, 35);
        run_phase(3'd0, 3'd5, 70, 30, 35);
        run_phase(3'd4, 3'd0, 85, 20, 45);
        run_phase(3'd7, 3'd7, 30, 50, 35);
        run_phase(MASK_W'($urandom_range(0, 7)), MASK_W'($urandom_range(0, 7)),
                  $urandom_range(20, 90), $urandom_range(10, 90), 30);
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        run_phase(3'd7, 3'd3, 55, 50, 30);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        inbound.valid      <= 1'b0;
        inbound.kind       <= KIND_PUBLISH;
        inbound.topic      <= 1'b0;
        inbound.subscriber <= '0;
        inbound.token      <= '0;
        cfg.valid          <= 1'b0;
        cfg.index          <= REG_TOPIC0_SUBS;
        cfg.data           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_default_masks();
        test_full_fanout();
        test_random_traffic();
        test_quiet_tail();
        settle();

        $display("Ran %0d items, %0d publishes, %0d ring overruns, %0d deliveries checked.",
                 items_sent, publishes, overwrites, delivered);
        $display("Up to %0d deliveries per item; subscriber masks reloaded %0d times.",
                 max_batch, mask_loads);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/mrtq_pkg.sv
sv/mrtq_ifs.sv
sv/mrtq_ram.sv
sv/multi_reader_topic_queue.sv
sv/mrtq_checker.sv
tb/multi_reader_topic_queue_tb.sv
